// ----- rtl/knap_pkg.sv -----
package knap_pkg;

  localparam int MAX_CAPACITY = 1024;
  localparam int IDX_W        = $clog2(MAX_CAPACITY);
  localparam int CNT_W        = $clog2(MAX_CAPACITY + 1);
  localparam int CAP_W        = 11;
  localparam int WEIGHT_W     = 16;
  localparam int VALUE_W      = 16;
  localparam int BEST_W       = 32;
  localparam int DATA_W       = 32;
  localparam int ADDR_W       = 3;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ADDR_W-3:0] REG_CAPACITY = '0;
  localparam logic [CAP_W-1:0]  CAPACITY_RESET = CAP_W'(1024);

  typedef struct packed {
    logic [CNT_W-1:0]   weight;
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               skip;
    logic [CNT_W-1:0]   cap;
    logic [CNT_W-1:0]   lo;
  } knap_job_t;

  typedef struct packed {
    logic      valid;
    knap_job_t job;
  } knap_qout_t;

endpackage

// ----- rtl/knap_if.sv -----
interface knap_item_if import knap_pkg::*;;
  logic                valid;
  logic                ready;
  logic [WEIGHT_W-1:0] item_weight;
  logic [VALUE_W-1:0]  item_value;
  logic                last_item;

  modport source (output valid, output item_weight, output item_value, output last_item,
                  input ready);
  modport sink   (input valid, input item_weight, input item_value, input last_item,
                  output ready);
endinterface

interface knap_result_if import knap_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BEST_W-1:0] best_value;

  modport source (output valid, output best_value, input ready);
  modport sink   (input valid, input best_value, output ready);
endinterface

// ----- rtl/knap_front.sv -----
module knap_front import knap_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CAP_W-1:0] cap_i,
  input  logic             clearing_i,
  knap_item_if.sink        item_i,
  output knap_qout_t       qout_o,
  input  logic             pop_i
);

  knap_job_t         q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;
  logic [31:0]       cap32, eff32, w32;
  knap_job_t         job;

  // classify the incoming word
  always_comb begin
    cap32      = 32'(cap_i);
    eff32      = (cap32 > 32'(MAX_CAPACITY)) ? 32'(MAX_CAPACITY) : cap32;
    w32        = 32'(item_i.item_weight);
    job.weight = w32[CNT_W-1:0];
    job.value  = item_i.item_value;
    job.last   = item_i.last_item;
    job.skip   = (w32 > eff32) || (eff32 == 32'd0);
    job.cap    = eff32[CNT_W-1:0];
    job.lo     = (w32 == 32'd0) ? CNT_W'(1) : w32[CNT_W-1:0];
  end

  assign item_i.ready = (count_q != QCNT_W'(QUEUE_DEPTH)) && !clearing_i;
  assign push         = item_i.valid && item_i.ready;
  assign pop          = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= job;
    end
  end

  assign qout_o.valid = (count_q != '0);
  assign qout_o.job   = q_mem[rd_ptr_q];

endmodule

// ----- rtl/knap_back.sv -----
module knap_back import knap_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  knap_qout_t qout_i,
  output logic       pop_o,
  output logic       clearing_o,
  knap_result_if.source result_o
);

  localparam logic [2:0] ST_FETCH  = 3'd0;
  localparam logic [2:0] ST_UPD    = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_RES_RD = 3'd3;
  localparam logic [2:0] ST_RES_WR = 3'd4;
  localparam logic [2:0] ST_CLR    = 3'd5;

  logic [BEST_W-1:0]  mem [MAX_CAPACITY];
  logic [BEST_W-1:0]  rd_a_q, rd_b_q;
  logic [IDX_W-1:0]   ra, rb, wa;
  logic               we;
  logic [BEST_W-1:0]  wd;

  logic [2:0]         state_q, state_d;
  logic [CNT_W-1:0]   j_q, j_d;
  logic [CNT_W-1:0]   w_q, cap_q, lo_q;
  logic [VALUE_W-1:0] v_q;
  logic               last_q;
  logic [IDX_W-1:0]   clr_q, clr_d;
  logic               load;

  logic               p1_valid_q, p1_valid_d;
  logic [IDX_W-1:0]   p1_addr_q;
  logic               p1_kzero_q;

  logic               out_valid_q, out_valid_d;
  logic [BEST_W-1:0]  out_data_q;
  logic               out_load;

  logic [CNT_W-1:0]   k, j_m1, k_m1, cap_m1;
  logic [BEST_W-1:0]  src;
  logic [BEST_W:0]    sum;
  logic [BEST_W-1:0]  cand;
  logic               upd_we;

  // read addresses for this step
  always_comb begin
    k      = j_q - w_q;
    j_m1   = j_q - CNT_W'(1);
    k_m1   = k - CNT_W'(1);
    cap_m1 = cap_q - CNT_W'(1);
    ra     = (state_q == ST_RES_RD) ? cap_m1[IDX_W-1:0] : j_m1[IDX_W-1:0];
    rb     = k_m1[IDX_W-1:0];
  end

  // candidate from the entry one weight below, saturated
  always_comb begin
    src    = p1_kzero_q ? '0 : rd_b_q;
    sum    = {1'b0, src} + (BEST_W + 1)'(v_q);
    cand   = sum[BEST_W] ? '1 : sum[BEST_W-1:0];
    upd_we = p1_valid_q && (cand > rd_a_q);
  end

  always_comb begin
    if (state_q == ST_CLR) begin
      we = 1'b1;
      wa = clr_q;
      wd = '0;
    end else begin
      we = upd_we;
      wa = p1_addr_q;
      wd = cand;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a_q <= mem[ra];
    rd_b_q <= mem[rb];
  end

  always_comb begin
    state_d     = state_q;
    j_d         = j_q;
    clr_d       = clr_q;
    load        = 1'b0;
    p1_valid_d  = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !result_o.ready;
    unique case (state_q)
      ST_FETCH: begin
        if (qout_i.valid) begin
          load = 1'b1;
          j_d  = qout_i.job.cap;
          priority if (!qout_i.job.skip) begin
            state_d = ST_UPD;
          end else if (qout_i.job.last) begin
            state_d = ST_RES_RD;
          end else begin
            state_d = ST_FETCH;
          end
        end
      end
      ST_UPD: begin
        p1_valid_d = 1'b1;
        if (j_q == lo_q) begin
          state_d = ST_DRAIN;
        end else begin
          j_d = j_q - CNT_W'(1);
        end
      end
      ST_DRAIN: begin
        state_d = last_q ? ST_RES_RD : ST_FETCH;
      end
      ST_RES_RD: begin
        if (!out_valid_q) begin
          state_d = ST_RES_WR;
        end
      end
      ST_RES_WR: begin
        out_load    = 1'b1;
        out_valid_d = 1'b1;
        clr_d       = '0;
        state_d     = ST_CLR;
      end
      ST_CLR: begin
        if (clr_q == IDX_W'(MAX_CAPACITY - 1)) begin
          state_d = ST_FETCH;
        end else begin
          clr_d = clr_q + IDX_W'(1);
        end
      end
      default: begin
        state_d = ST_CLR;
        clr_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      p1_valid_q  <= p1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q        <= j_d;
    p1_addr_q  <= j_m1[IDX_W-1:0];
    p1_kzero_q <= (k == '0);
    if (load) begin
      w_q    <= qout_i.job.weight;
      v_q    <= qout_i.job.value;
      last_q <= qout_i.job.last;
      cap_q  <= qout_i.job.cap;
      lo_q   <= qout_i.job.lo;
    end
    if (out_load) begin
      out_data_q <= (cap_q == '0) ? '0 : rd_a_q;
    end
  end

  assign pop_o               = load;
  assign clearing_o          = (state_q == ST_CLR);
  assign result_o.valid      = out_valid_q;
  assign result_o.best_value = out_data_q;

  a_upd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD |-> j_q >= lo_q)
    else $error("sweep index below item weight");

  a_pipe_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_valid_q |-> (state_q == ST_UPD || state_q == ST_DRAIN))
    else $error("update pipeline busy outside sweep");

  a_res_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RES_WR |-> !out_valid_q)
    else $error("result register overwritten");

  a_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_RES_WR)
    else $error("result raised outside result step");

endmodule

// ----- rtl/zero_one_knapsack_table_top.sv -----
// a word of weight w within capacity c is swept from table entry c down to entry max(w,1),
//   one table entry per cycle through the two-read, one-write table memory
// a word above capacity is skipped without a sweep; the last word is followed by the result read
//   and then by a clearing pass over all MAX_CAPACITY entries, during which no word is taken
// reset: capacity goes to 1024 and a clearing pass over the MAX_CAPACITY (1024) entries
//   zeroes the table before the first word is taken
module zero_one_knapsack_table_top import knap_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  knap_item_if.sink         item_i,
  knap_result_if.source     result_o,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [DATA_W-1:0] pwdata_i,
  output logic [DATA_W-1:0] prdata_o,
  output logic              pready_o
);

  logic [CAP_W-1:0]  cap_q;
  logic [ADDR_W-3:0] reg_idx;
  logic              cfg_we;
  knap_qout_t        qout;
  logic              pop;
  logic              clearing;

  assign reg_idx  = paddr_i[ADDR_W-1:2];
  assign pready_o = 1'b1;
  assign cfg_we   = psel_i && penable_i && pwrite_i && pready_o && (reg_idx == REG_CAPACITY);
  assign prdata_o = (reg_idx == REG_CAPACITY) ? DATA_W'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAPACITY_RESET;
    end else if (cfg_we) begin
      cap_q <= pwdata_i[CAP_W-1:0];
    end
  end

  knap_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cap_i      (cap_q),
    .clearing_i (clearing),
    .item_i     (item_i),
    .qout_o     (qout),
    .pop_i      (pop)
  );

  knap_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .qout_i     (qout),
    .pop_o      (pop),
    .clearing_o (clearing),
    .result_o   (result_o)
  );

endmodule
